>>> rtl/core/aabb_pkg.sv
// Shared definitions for the box transform core: register indexes,
// register reset values and the stage enable bundle.
// No dependencies.
package aabb_pkg;

   // Width of the configuration write data and of each packed coefficient row.
   localparam int REG_WIDTH = 48;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int NUM_AXES = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ROW_X    = 3'd0,
      CSR_ROW_Y    = 3'd1,
      CSR_ROW_Z    = 3'd2,
      CSR_OFFSET_X = 3'd3,
      CSR_OFFSET_Y = 3'd4,
      CSR_OFFSET_Z = 3'd5
   } aabb_csr_type;

   // Identity matrix in Q2.14, one coefficient per row.
   localparam logic [REG_WIDTH-1:0] ROW_X_RESET = 48'h0000_0000_4000;
   localparam logic [REG_WIDTH-1:0] ROW_Y_RESET = 48'h0000_4000_0000;
   localparam logic [REG_WIDTH-1:0] ROW_Z_RESET = 48'h4000_0000_0000;

   // Load enables for the three stages inside each term unit.
   typedef struct packed {
      logic mult;
      logic scale;
      logic order;
   } aabb_stage_en_type;

endpackage

>>> rtl/core/aabb_affine_transform_core.sv
// Top level of the box transform core: configuration registers, pipeline
// control, nine term units, the row sums and saturation.
// Depends on aabb_pkg and aabb_term_unit.
//
// Usage: a box (min and max corner, signed Q16.16) is offered on the req_
// channel and is taken at a clock edge where req_valid is high and req_stall
// is low. The tight box of its image under the configured matrix and
// translation comes back on the rsp_ channel, one result per box, in order.
// A box passes these register stages on its way to the rsp_ channel: partial
// products, product assembly and floor, ordering of each term, row sum, and
// saturation into the output register. One box can enter in every cycle while
// req_stall is low; throughput is one box per cycle.
// When the receiver holds rsp_stall, the result stays on the rsp_ ports and
// the stages behind it keep filling until each holds a box; req_stall rises
// only when the pipeline is full up to the first stage. Configuration must be
// written through csr_wen, csr_index and csr_wdata while no box is in flight;
// the core does not enforce this. Synchronous reset empties the pipeline and
// loads the identity matrix and a zero translation; it needs no clearing pass.
module aabb_affine_transform_core #(
   parameter int COORD_WIDTH = 32,
   parameter int COEF_WIDTH = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_wen,
   input  logic [aabb_pkg::CSR_INDEX_WIDTH-1:0]          csr_index,
   input  logic [aabb_pkg::REG_WIDTH-1:0]                csr_wdata,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  logic signed [COORD_WIDTH-1:0]                 req_in_min_x,
   input  logic signed [COORD_WIDTH-1:0]                 req_in_min_y,
   input  logic signed [COORD_WIDTH-1:0]                 req_in_min_z,
   input  logic signed [COORD_WIDTH-1:0]                 req_in_max_x,
   input  logic signed [COORD_WIDTH-1:0]                 req_in_max_y,
   input  logic signed [COORD_WIDTH-1:0]                 req_in_max_z,
   output logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0]                 rsp_out_min_x,
   output logic signed [COORD_WIDTH-1:0]                 rsp_out_min_y,
   output logic signed [COORD_WIDTH-1:0]                 rsp_out_min_z,
   output logic signed [COORD_WIDTH-1:0]                 rsp_out_max_x,
   output logic signed [COORD_WIDTH-1:0]                 rsp_out_max_y,
   output logic signed [COORD_WIDTH-1:0]                 rsp_out_max_z
);

   localparam int AXES = aabb_pkg::NUM_AXES;
   localparam int REG_W = aabb_pkg::REG_WIDTH;
   localparam int ROW_EXT_W = 3 * COEF_WIDTH;
   localparam int TERM_W = COORD_WIDTH + 2;
   localparam int SUM_W = COORD_WIDTH + 4;
   localparam int SAT_TOP_W = SUM_W - COORD_WIDTH + 1;

   logic [REG_W-1:0]              row_ff    [AXES];
   logic [REG_W-1:0]              row_in    [AXES];
   logic signed [COORD_WIDTH-1:0] offset_ff [AXES];
   logic signed [COORD_WIDTH-1:0] offset_in [AXES];
   logic [ROW_EXT_W-1:0]          row_ext   [AXES];

   logic signed [COORD_WIDTH-1:0] bound_lo [AXES];
   logic signed [COORD_WIDTH-1:0] bound_hi [AXES];
   logic signed [TERM_W-1:0]      term_min [AXES][AXES];
   logic signed [TERM_W-1:0]      term_max [AXES][AXES];

   logic signed [SUM_W-1:0]       sum_min_in  [AXES];
   logic signed [SUM_W-1:0]       sum_max_in  [AXES];
   logic signed [SUM_W-1:0]       sum_min_ff  [AXES];
   logic signed [SUM_W-1:0]       sum_max_ff  [AXES];
   logic signed [COORD_WIDTH-1:0] out_min_in  [AXES];
   logic signed [COORD_WIDTH-1:0] out_max_in  [AXES];
   logic signed [COORD_WIDTH-1:0] out_min_ff  [AXES];
   logic signed [COORD_WIDTH-1:0] out_max_ff  [AXES];

   logic [4:0] valid_ff;
   logic [4:0] valid_in;
   logic [4:0] ready;
   aabb_pkg::aabb_stage_en_type term_en;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   always_comb begin
      row_in = row_ff;
      offset_in = offset_ff;
      if (csr_wen) begin
         unique case (aabb_pkg::aabb_csr_type'(csr_index))
            aabb_pkg::CSR_ROW_X:    row_in[0] = csr_wdata;
            aabb_pkg::CSR_ROW_Y:    row_in[1] = csr_wdata;
            aabb_pkg::CSR_ROW_Z:    row_in[2] = csr_wdata;
            aabb_pkg::CSR_OFFSET_X: offset_in[0] = csr_wdata[COORD_WIDTH-1:0];
            aabb_pkg::CSR_OFFSET_Y: offset_in[1] = csr_wdata[COORD_WIDTH-1:0];
            aabb_pkg::CSR_OFFSET_Z: offset_in[2] = csr_wdata[COORD_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= aabb_pkg::ROW_X_RESET;
         row_ff[1] <= aabb_pkg::ROW_Y_RESET;
         row_ff[2] <= aabb_pkg::ROW_Z_RESET;
         for (int i = 0; i < AXES; i++) begin
            offset_ff[i] <= '0;
         end
      end else begin
         row_ff <= row_in;
         offset_ff <= offset_in;
      end
   end

   // Coefficient fields that reach past the register read as zero.
   for (genvar i = 0; i < AXES; i++) begin : g_row_ext
      if (ROW_EXT_W > REG_W) begin : g_pad
         assign row_ext[i] = {{(ROW_EXT_W - REG_W){1'b0}}, row_ff[i]};
      end else begin : g_trim
         assign row_ext[i] = row_ff[i][ROW_EXT_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Pipeline control: a stage loads when it is empty or its
   // successor loads in the same cycle.
   // ---------------------------------------------------------------
   always_comb begin
      ready[4] = !valid_ff[4] || !rsp_stall;
      for (int s = 3; s >= 0; s--) begin
         ready[s] = !valid_ff[s] || ready[s+1];
      end
      valid_in = valid_ff;
      if (ready[0]) valid_in[0] = req_valid;
      for (int s = 1; s < 5; s++) begin
         if (ready[s]) valid_in[s] = valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !ready[0];
   assign term_en.mult = ready[0];
   assign term_en.scale = ready[1];
   assign term_en.order = ready[2];

   // ---------------------------------------------------------------
   // Term units: output axis i, input axis j.
   // ---------------------------------------------------------------
   assign bound_lo[0] = req_in_min_x;
   assign bound_lo[1] = req_in_min_y;
   assign bound_lo[2] = req_in_min_z;
   assign bound_hi[0] = req_in_max_x;
   assign bound_hi[1] = req_in_max_y;
   assign bound_hi[2] = req_in_max_z;

   for (genvar i = 0; i < AXES; i++) begin : g_row
      for (genvar j = 0; j < AXES; j++) begin : g_col
         aabb_term_unit #(
            .COORD_WIDTH (COORD_WIDTH),
            .COEF_WIDTH  (COEF_WIDTH)
         ) u_term (
            .clock    (clock),
            .stage_en (term_en),
            .coef     ($signed(row_ext[i][j*COEF_WIDTH +: COEF_WIDTH])),
            .bound_lo (bound_lo[j]),
            .bound_hi (bound_hi[j]),
            .term_min (term_min[i][j]),
            .term_max (term_max[i][j])
         );
      end
   end

   // ---------------------------------------------------------------
   // Row sums and saturation
   // ---------------------------------------------------------------
   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         sum_min_in[i] = SUM_W'(offset_ff[i]) + SUM_W'(term_min[i][0])
                       + SUM_W'(term_min[i][1]) + SUM_W'(term_min[i][2]);
         sum_max_in[i] = SUM_W'(offset_ff[i]) + SUM_W'(term_max[i][0])
                       + SUM_W'(term_max[i][1]) + SUM_W'(term_max[i][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         sum_min_ff <= sum_min_in;
         sum_max_ff <= sum_max_in;
      end
   end

   // A sum fits when its bits above the coordinate sign all equal that sign.
   function automatic logic signed [COORD_WIDTH-1:0] saturate(
      input logic signed [SUM_W-1:0] value
   );
      logic [SAT_TOP_W-1:0] top;
      top = value[SUM_W-1:COORD_WIDTH-1];
      if (top == '0 || top == '1) begin
         saturate = value[COORD_WIDTH-1:0];
      end else if (value[SUM_W-1]) begin
         saturate = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         saturate = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   endfunction

   always_comb begin
      for (int i = 0; i < AXES; i++) begin
         out_min_in[i] = saturate(sum_min_ff[i]);
         out_max_in[i] = saturate(sum_max_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ready[4]) begin
         out_min_ff <= out_min_in;
         out_max_ff <= out_max_in;
      end
   end

   assign rsp_valid = valid_ff[4];
   assign rsp_out_min_x = out_min_ff[0];
   assign rsp_out_min_y = out_min_ff[1];
   assign rsp_out_min_z = out_min_ff[2];
   assign rsp_out_max_x = out_max_ff[0];
   assign rsp_out_max_y = out_max_ff[1];
   assign rsp_out_max_z = out_max_ff[2];

endmodule

>>> rtl/core/aabb_term_unit.sv
// One matrix term: the coefficient times both bounds of one input axis,
// floored to coordinate format and put in order. Three register stages.
// Depends on aabb_pkg.
module aabb_term_unit #(
   parameter int COORD_WIDTH = 32,
   parameter int COEF_WIDTH = 16
) (
   input  logic                          clock,
   input  aabb_pkg::aabb_stage_en_type   stage_en,
   input  logic signed [COEF_WIDTH-1:0]  coef,
   input  logic signed [COORD_WIDTH-1:0] bound_lo,
   input  logic signed [COORD_WIDTH-1:0] bound_hi,
   output logic signed [COORD_WIDTH+1:0] term_min,
   output logic signed [COORD_WIDTH+1:0] term_max
);

   localparam int LO_W = COORD_WIDTH / 2;
   localparam int HI_W = COORD_WIDTH - LO_W;
   localparam int PH_W = COEF_WIDTH + HI_W;
   localparam int PL_W = COEF_WIDTH + LO_W + 1;
   localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;
   localparam int FRAC = COEF_WIDTH - 2;
   localparam int TERM_W = COORD_WIDTH + 2;

   logic signed [COORD_WIDTH-1:0] bound [2];
   logic signed [PH_W-1:0]        ph_in [2];
   logic signed [PH_W-1:0]        ph_ff [2];
   logic signed [PL_W-1:0]        pl_in [2];
   logic signed [PL_W-1:0]        pl_ff [2];
   logic signed [PROD_W-1:0]      prod  [2];
   logic signed [TERM_W-1:0]      scaled_in [2];
   logic signed [TERM_W-1:0]      scaled_ff [2];
   logic signed [TERM_W-1:0]      min_in;
   logic signed [TERM_W-1:0]      max_in;
   logic signed [TERM_W-1:0]      min_ff;
   logic signed [TERM_W-1:0]      max_ff;

   assign bound[0] = bound_lo;
   assign bound[1] = bound_hi;

   // Each bound is split into a signed upper half and an unsigned lower half,
   // so that each multiplier takes only about half of the bound's bits.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         ph_in[k] = coef * $signed(bound[k][COORD_WIDTH-1:LO_W]);
         pl_in[k] = coef * $signed({1'b0, bound[k][LO_W-1:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.mult) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
   end

   // The arithmetic shift of the exact product floors toward minus infinity.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         prod[k] = (PROD_W'(ph_ff[k]) <<< LO_W) + PROD_W'(pl_ff[k]);
         scaled_in[k] = prod[k][PROD_W-1:FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.scale) begin
         scaled_ff <= scaled_in;
      end
   end

   always_comb begin
      if (scaled_ff[0] < scaled_ff[1]) begin
         min_in = scaled_ff[0];
         max_in = scaled_ff[1];
      end else begin
         min_in = scaled_ff[1];
         max_in = scaled_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.order) begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   assign term_min = min_ff;
   assign term_max = max_ff;

endmodule

>>> rtl/core/aabb_checker.sv
// Port-level checks for the box transform core, attached by bind.
// Depends on aabb_affine_transform_core.
module aabb_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [COORD_WIDTH-1:0]        rsp_out_min_x,
   input logic signed [COORD_WIDTH-1:0]        rsp_out_min_y,
   input logic signed [COORD_WIDTH-1:0]        rsp_out_min_z,
   input logic signed [COORD_WIDTH-1:0]        rsp_out_max_x,
   input logic signed [COORD_WIDTH-1:0]        rsp_out_max_y,
   input logic signed [COORD_WIDTH-1:0]        rsp_out_max_z
);

   // Reset empties the pipeline, so no result is shown right after it.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // With a free output every stage can advance, so the input never stalls.
   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

   // Each term adds its smaller product to the min, and saturation is
   // monotonic, so the result box is never inverted.
   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_min_x <= rsp_out_max_x) && (rsp_out_min_y <= rsp_out_max_y)
                    && (rsp_out_min_z <= rsp_out_max_z))
      else $error("transformed box has min above max");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_min_x)
         && $stable(rsp_out_min_y) && $stable(rsp_out_min_z)
         && $stable(rsp_out_max_x) && $stable(rsp_out_max_y)
         && $stable(rsp_out_max_z))
      else $error("stalled result dropped or changed");

endmodule

bind aabb_affine_transform_core aabb_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_aabb_checker (.*);
